// ===== hdl/qdbd_pkg.sv =====
// ----------------------------------------------------------------------------
// qdbd_pkg
// shared types, constants and helpers of the quadrature detent and
// button debounce unit
// ----------------------------------------------------------------------------
package qdbd_pkg;

   localparam int TIME_BITS = 32;
   localparam int NUM_BUTTONS = 4;

   typedef logic [TIME_BITS-1:0] time_type;

   // button positions inside button_levels / stable_levels
   localparam int BTN_A    = 0;
   localparam int BTN_B    = 1;
   localparam int BTN_UP   = 2;
   localparam int BTN_DOWN = 3;

   // event bit positions
   localparam int EV_A_PRESS    = 0;
   localparam int EV_A_RELEASE  = 1;
   localparam int EV_B_PRESS    = 2;
   localparam int EV_B_RELEASE  = 3;
   localparam int EV_UP_PRESS   = 4;
   localparam int EV_UP_RELEASE = 5;
   localparam int EV_UP_LONG    = 6;
   localparam int EV_DN_PRESS   = 7;
   localparam int EV_DN_RELEASE = 8;
   localparam int EV_DN_LONG    = 9;

   // configuration register indexes
   localparam logic [2:0] CSR_EDGES_PER_DETENT = 3'd0;
   localparam logic [2:0] CSR_INVERT_DIRECTION = 3'd1;
   localparam logic [2:0] CSR_BUTTON_ENABLE    = 3'd2;
   localparam logic [2:0] CSR_DEBOUNCE_TIME    = 3'd3;
   localparam logic [2:0] CSR_LONG_PRESS_TIME  = 3'd4;
   localparam logic [2:0] CSR_REPEAT_DELAY     = 3'd5;
   localparam logic [2:0] CSR_REPEAT_PERIOD    = 3'd6;

   // configuration reset values
   localparam logic [3:0]  RST_EDGES_PER_DETENT = 4'd4;
   localparam logic        RST_INVERT_DIRECTION = 1'b0;
   localparam logic [3:0]  RST_BUTTON_ENABLE    = 4'd3;
   localparam logic [15:0] RST_DEBOUNCE_TIME    = 16'd20;
   localparam logic [15:0] RST_LONG_PRESS_TIME  = 16'd600;
   localparam logic [15:0] RST_REPEAT_DELAY     = 16'd400;
   localparam logic [15:0] RST_REPEAT_PERIOD    = 16'd100;

   typedef struct packed {
      logic        line_a;
      logic        line_b;
      logic [3:0]  button_levels;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic signed [1:0] encoder_detent;
      logic [1:0]        up_steps;
      logic [1:0]        down_steps;
      logic [9:0]        button_events;
      logic [3:0]        stable_levels;
   } rsp_type;

   // what one debounce lane reports for the current sample
   typedef struct packed {
      logic press;
      logic release_ev;
      logic level;
   } deb_result_type;

   // what one hold lane reports for the current sample
   typedef struct packed {
      logic [1:0] steps;
      logic       long_ev;
   } hold_result_type;

   // quadrature transition table, index {previous ab, current ab}
   function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
      logic signed [1:0] s;
      unique case (idx)
         4'd1, 4'd7, 4'd8, 4'd14:  s = 2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: s = -2'sd1;
         default:                  s = 2'sd0;
      endcase
      return s;
   endfunction

   // wrapping elapsed time compared against a 16-bit limit
   function automatic logic time_reached(input time_type now, input time_type since,
                                         input logic [15:0] limit);
      time_type diff;
      diff = now - since;
      return diff >= TIME_BITS'(limit);
   endfunction

endpackage

// ===== hdl/quadrature_detent_and_button_debounce_unit.sv =====
// ----------------------------------------------------------------------------
// quadrature_detent_and_button_debounce_unit
// rotary encoder detent decoder plus debounce, long-press and auto-repeat
// for four active-low buttons, one result per sample tick
// ----------------------------------------------------------------------------
// Every accepted sample gives exactly one result in the cycle after it. A
// new sample is taken every cycle as long as the result register is empty
// or its contents are transferred in the same cycle, so the sustained rate
// is one sample per clock. The encoder lane, four debounce lanes and two
// hold lanes all work on the same sample in parallel and their findings
// are merged into the result register. Time comparisons use the sample's
// timestamp and wrap modulo 2^32. The user must write registers through
// the csr port only while the unit holds no pending sample; the unit
// itself does not enforce this. Index 0 edges per detent, 1 invert,
// 2 button enable, 3 debounce time, 4 long-press time, 5 repeat delay,
// 6 repeat period. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module quadrature_detent_and_button_debounce_unit (
   input  logic              clock,
   input  logic              reset,
   // sample channel
   input  logic              req_valid,
   output logic              req_ready,
   input  qdbd_pkg::req_type req_data,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qdbd_pkg::rsp_type rsp_data,
   // register writes
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import qdbd_pkg::*;

   // configuration registers
   logic [3:0]  epd_ff;
   logic        invert_ff;
   logic [3:0]  enable_ff;
   logic [15:0] debounce_ff;
   logic [15:0] long_ff;
   logic [15:0] rep_delay_ff;
   logic [15:0] rep_period_ff;

   // output stage
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic              take;
   time_type          now;
   logic signed [1:0] detent;
   deb_result_type    deb [NUM_BUTTONS];
   hold_result_type   hold_up, hold_dn;

   // a sample can move in whenever the result register frees up this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take = req_valid && req_ready;
   assign now = TIME_BITS'(req_data.now_ms);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         epd_ff <= RST_EDGES_PER_DETENT;
         invert_ff <= RST_INVERT_DIRECTION;
         enable_ff <= RST_BUTTON_ENABLE;
         debounce_ff <= RST_DEBOUNCE_TIME;
         long_ff <= RST_LONG_PRESS_TIME;
         rep_delay_ff <= RST_REPEAT_DELAY;
         rep_period_ff <= RST_REPEAT_PERIOD;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EDGES_PER_DETENT: epd_ff <= csr_wdata[3:0];
            CSR_INVERT_DIRECTION: invert_ff <= csr_wdata[0];
            CSR_BUTTON_ENABLE:    enable_ff <= csr_wdata[3:0];
            CSR_DEBOUNCE_TIME:    debounce_ff <= csr_wdata;
            CSR_LONG_PRESS_TIME:  long_ff <= csr_wdata;
            CSR_REPEAT_DELAY:     rep_delay_ff <= csr_wdata;
            CSR_REPEAT_PERIOD:    rep_period_ff <= csr_wdata;
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // encoder lane
   qdbd_quad u_quad (
      .clock            (clock),
      .reset            (reset),
      .take             (take),
      .line_a           (req_data.line_a),
      .line_b           (req_data.line_b),
      .edges_per_detent (epd_ff),
      .invert_direction (invert_ff),
      .detent           (detent)
   );

   // one debounce lane per button
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_deb
      qdbd_debounce u_deb (
         .clock         (clock),
         .reset         (reset),
         .take          (take),
         .enable        (enable_ff[i]),
         .raw           (req_data.button_levels[i]),
         .now           (now),
         .debounce_time (debounce_ff),
         .result        (deb[i])
      );
   end

   // hold lanes for up and down
   qdbd_hold u_hold_up (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .enable          (enable_ff[BTN_UP]),
      .deb             (deb[BTN_UP]),
      .now             (now),
      .long_press_time (long_ff),
      .repeat_delay    (rep_delay_ff),
      .repeat_period   (rep_period_ff),
      .result          (hold_up)
   );

   qdbd_hold u_hold_dn (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .enable          (enable_ff[BTN_DOWN]),
      .deb             (deb[BTN_DOWN]),
      .now             (now),
      .long_press_time (long_ff),
      .repeat_delay    (rep_delay_ff),
      .repeat_period   (rep_period_ff),
      .result          (hold_dn)
   );

   // merge what the lanes found into one result
   always_comb begin
      rsp_in = '0;
      rsp_in.encoder_detent = detent;
      rsp_in.up_steps = hold_up.steps;
      rsp_in.down_steps = hold_dn.steps;
      rsp_in.button_events[EV_A_PRESS] = deb[BTN_A].press;
      rsp_in.button_events[EV_A_RELEASE] = deb[BTN_A].release_ev;
      rsp_in.button_events[EV_B_PRESS] = deb[BTN_B].press;
      rsp_in.button_events[EV_B_RELEASE] = deb[BTN_B].release_ev;
      rsp_in.button_events[EV_UP_PRESS] = deb[BTN_UP].press;
      rsp_in.button_events[EV_UP_RELEASE] = deb[BTN_UP].release_ev;
      rsp_in.button_events[EV_UP_LONG] = hold_up.long_ev;
      rsp_in.button_events[EV_DN_PRESS] = deb[BTN_DOWN].press;
      rsp_in.button_events[EV_DN_RELEASE] = deb[BTN_DOWN].release_ev;
      rsp_in.button_events[EV_DN_LONG] = hold_dn.long_ev;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         rsp_in.stable_levels[i] = deb[i].level;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   // every accepted sample shows up as a result on the next cycle
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("accepted sample produced no result");

   // a waiting result is never overwritten
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !take)
      else $error("result overwritten while stalled");

   // detent is only -1, 0 or +1
   a_detent_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.encoder_detent != 2'b10)
      else $error("detent out of range");

   // a long press is only reported while the button is held down
   a_long_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.button_events[EV_UP_LONG] |-> !rsp_ff.stable_levels[BTN_UP])
      else $error("long press on released up button");

endmodule

// ===== hdl/qdbd_quad.sv =====
// ----------------------------------------------------------------------------
// qdbd_quad
// quadrature decoder lane with edge accumulation and detent output
// ----------------------------------------------------------------------------
module qdbd_quad (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic              line_a,
   input  logic              line_b,
   input  logic [3:0]        edges_per_detent,
   input  logic              invert_direction,
   output logic signed [1:0] detent
);
   import qdbd_pkg::*;

   logic [1:0]        last_ab_ff, last_ab_in;
   logic signed [4:0] acc_ff, acc_in;
   logic signed [1:0] step;
   logic signed [5:0] sum;
   logic signed [5:0] e;
   logic [1:0]        curr;

   assign curr = {line_a, line_b};

   always_comb begin
      step = quad_step({last_ab_ff, curr});
      if (invert_direction) begin
         step = -step;
      end
      e = (edges_per_detent == 4'd0) ? 6'sd1 : $signed({2'b00, edges_per_detent});
      sum = 6'(acc_ff) + 6'(step);
      last_ab_in = last_ab_ff;
      acc_in = acc_ff;
      detent = 2'sd0;
      if (step != 2'sd0) begin
         last_ab_in = curr;
         priority if (sum >= e) begin
            acc_in = 5'(sum - e);
            detent = 2'sd1;
         end else if (sum <= -e) begin
            acc_in = 5'(sum + e);
            detent = -2'sd1;
         end else begin
            acc_in = 5'(sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ab_ff <= 2'b11;
         acc_ff <= 5'sd0;
      end else if (take) begin
         last_ab_ff <= last_ab_in;
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== hdl/qdbd_debounce.sv =====
// ----------------------------------------------------------------------------
// qdbd_debounce
// time-based debounce lane for one active-low button
// ----------------------------------------------------------------------------
module qdbd_debounce (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic                      enable,
   input  logic                      raw,
   input  qdbd_pkg::time_type        now,
   input  logic [15:0]               debounce_time,
   output qdbd_pkg::deb_result_type  result
);
   import qdbd_pkg::*;

   logic     raw_prev_ff;
   logic     level_ff;
   time_type changed_ff;
   logic     raw_changed;
   logic     commit;

   always_comb begin
      raw_changed = raw != raw_prev_ff;
      commit = enable && !raw_changed && (raw != level_ff) &&
               time_reached(now, changed_ff, debounce_time);
      result.press = commit && !raw;
      result.release_ev = commit && raw;
      result.level = commit ? raw : level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff <= 1'b1;
         level_ff <= 1'b1;
         changed_ff <= '0;
      end else if (take && enable) begin
         if (raw_changed) begin
            raw_prev_ff <= raw;
            changed_ff <= now;
         end else if (commit) begin
            level_ff <= raw;
         end
      end
   end

endmodule

// ===== hdl/qdbd_hold.sv =====
// ----------------------------------------------------------------------------
// qdbd_hold
// tap, long-press and auto-repeat lane behind a debounced button
// ----------------------------------------------------------------------------
module qdbd_hold (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic                      enable,
   input  qdbd_pkg::deb_result_type  deb,
   input  qdbd_pkg::time_type        now,
   input  logic [15:0]               long_press_time,
   input  logic [15:0]               repeat_delay,
   input  logic [15:0]               repeat_period,
   output qdbd_pkg::hold_result_type result
);
   import qdbd_pkg::*;

   time_type pressed_ff;
   time_type last_rep_ff;
   logic     long_ff;
   time_type pt;
   time_type lr;
   logic     lf;
   logic     held;
   logic     rep;

   always_comb begin
      // a fresh press restarts both timers this very tick
      pt = deb.press ? now : pressed_ff;
      lr = deb.press ? now : last_rep_ff;
      lf = (deb.press || deb.release_ev) ? 1'b0 : long_ff;
      held = enable && !deb.level;
      result.long_ev = held && !lf && time_reached(now, pt, long_press_time);
      rep = held && time_reached(now, pt, repeat_delay) &&
            time_reached(now, lr, repeat_period);
      result.steps = {1'b0, deb.press} + {1'b0, rep};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= '0;
         last_rep_ff <= '0;
         long_ff <= 1'b0;
      end else if (take && enable) begin
         pressed_ff <= pt;
         last_rep_ff <= rep ? now : lr;
         long_ff <= lf || result.long_ev;
      end
   end

endmodule
